// File: hw/rtl/lmcfb_pkg.sv
`timescale 1ns / 1ps
package lmcfb_pkg;

  localparam int unsigned MAX_CHAIN       = 8;
  localparam int unsigned ROWS_PER_DEVICE = 8;
  localparam int unsigned DESC_FIFO_DEPTH = 4;

  localparam logic [2:0] MODE_LED       = 3'd0;
  localparam logic [2:0] MODE_ROW       = 3'd1;
  localparam logic [2:0] MODE_COLUMN    = 3'd2;
  localparam logic [2:0] MODE_SHUTDOWN  = 3'd3;
  localparam logic [2:0] MODE_INTENSITY = 3'd4;
  localparam logic [2:0] MODE_SCANLIMIT = 3'd5;
  localparam logic [2:0] MODE_CLEAR     = 3'd6;
  localparam logic [2:0] MODE_REGWRITE  = 3'd7;

  localparam logic [3:0] OPC_INTENSITY = 4'd10;
  localparam logic [3:0] OPC_SCANLIMIT = 4'd11;
  localparam logic [3:0] OPC_SHUTDOWN  = 4'd12;

  localparam logic [7:0] INTENSITY_LIMIT = 8'd16;
  localparam logic [7:0] SCANLIMIT_LIMIT = 8'd8;
  localparam logic [2:0] LAST_ROW        = 3'd7;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] device;
    logic [2:0] row;
    logic [2:0] column;
    logic [7:0] value;
    logic       on;
    logic [3:0] reg_opcode;
  } cmd_t;

  typedef struct packed {
    logic [15:0] frame_word;
    logic        frame_end;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [2:0] device;
    logic [3:0] opcode;
    logic [7:0] data;
    logic       last;
  } desc_t;

endpackage

// File: hw/rtl/lmcfb_fifo.sv
`timescale 1ns / 1ps
module lmcfb_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lmcfb_pkg::desc_t     push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output lmcfb_pkg::desc_t     pop_data_o,
  output logic                 empty_o
);
  import lmcfb_pkg::*;

  localparam int unsigned PtrW = $clog2(DESC_FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(DESC_FIFO_DEPTH + 1);

  desc_t            slot_q [DESC_FIFO_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(DESC_FIFO_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = slot_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DESC_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DESC_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/lmcfb_front.sv
`timescale 1ns / 1ps
module lmcfb_front #(
  parameter int unsigned MaxChain = lmcfb_pkg::MAX_CHAIN
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lmcfb_pkg::cmd_t   cmd_i,
  input  logic [3:0]        chain_len_i,
  output logic              push_o,
  output lmcfb_pkg::desc_t  push_data_o,
  input  logic              full_i
);
  import lmcfb_pkg::*;

  localparam int unsigned Depth = MaxChain * ROWS_PER_DEVICE;
  localparam int unsigned AddrW = $clog2(Depth);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]       state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [2:0]       row_q, row_d;
  logic [7:0]       mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [7:0]       rd_data_q;
  logic             rd_vld_q;
  logic [5:0]       idx;
  logic [AddrW-1:0] addr;
  logic             accept, drop, multi, more;
  logic [7:0]       old_byte, mask, rmw_byte;
  logic             led_on;
  logic             we;
  logic [7:0]       wdata;
  desc_t            desc;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign idx    = {cmd_q.device, row_q};
  assign addr   = idx[AddrW-1:0];

  always_comb begin
    drop = ({1'b0, cmd_i.device} >= chain_len_i);
    if (cmd_i.mode == MODE_INTENSITY && cmd_i.value >= INTENSITY_LIMIT) begin
      drop = 1'b1;
    end
    if (cmd_i.mode == MODE_SCANLIMIT && cmd_i.value >= SCANLIMIT_LIMIT) begin
      drop = 1'b1;
    end
  end

  assign old_byte = rd_vld_q ? rd_data_q : 8'h00;
  assign mask     = 8'h80 >> cmd_q.column;
  assign led_on   = (cmd_q.mode == MODE_COLUMN) ? cmd_q.value[LAST_ROW - row_q] : cmd_q.on;
  assign rmw_byte = led_on ? (old_byte | mask) : (old_byte & ~mask);
  assign multi    = (cmd_q.mode == MODE_COLUMN) || (cmd_q.mode == MODE_CLEAR);
  assign more     = multi && (row_q != LAST_ROW);

  always_comb begin
    desc.device = cmd_q.device;
    desc.last   = !more;
    desc.opcode = {1'b0, row_q} + 4'd1;
    desc.data   = cmd_q.value;
    we          = 1'b0;
    unique case (cmd_q.mode) inside
      MODE_LED, MODE_COLUMN: begin
        desc.data = rmw_byte;
        we        = 1'b1;
      end
      MODE_ROW: begin
        we = 1'b1;
      end
      MODE_CLEAR: begin
        desc.data = 8'h00;
        we        = 1'b1;
      end
      MODE_SHUTDOWN: begin
        desc.opcode = OPC_SHUTDOWN;
        desc.data   = {7'd0, ~cmd_q.on};
      end
      MODE_INTENSITY: desc.opcode = OPC_INTENSITY;
      MODE_SCANLIMIT: desc.opcode = OPC_SCANLIMIT;
      default:        desc.opcode = cmd_q.reg_opcode;
    endcase
  end

  assign wdata       = desc.data;
  assign push_o      = (state_q == S_EMIT) && !full_i;
  assign push_data_o = desc;

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    row_d   = row_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !drop) begin
          cmd_d = cmd_i;
          row_d = ((cmd_i.mode == MODE_COLUMN) || (cmd_i.mode == MODE_CLEAR)) ? 3'd0 : cmd_i.row;
          state_d = ((cmd_i.mode == MODE_LED) || (cmd_i.mode == MODE_COLUMN)) ? S_READ : S_EMIT;
        end
      end
      S_READ: state_d = S_EMIT;
      S_EMIT: begin
        if (!full_i) begin
          if (more) begin
            row_d   = row_q + 3'd1;
            state_d = (cmd_q.mode == MODE_COLUMN) ? S_READ : S_EMIT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      if (push_o && we) begin
        vld_q[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    row_q <= row_d;
  end

  always_ff @(posedge clk_i) begin
    if (push_o && we) begin
      mem[addr] <= wdata;
    end
    rd_data_q <= mem[addr];
    rd_vld_q  <= vld_q[addr];
  end

endmodule

// File: hw/rtl/lmcfb_back.sv
`timescale 1ns / 1ps
module lmcfb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [3:0]        chain_len_i,
  output logic              pop_o,
  input  lmcfb_pkg::desc_t  pop_data_i,
  input  logic              empty_i,
  output logic              res_strobe_o,
  output lmcfb_pkg::res_t   res_o
);
  import lmcfb_pkg::*;

  logic       active_q, active_d;
  desc_t      desc_q;
  logic [2:0] chip_q, chip_d;
  logic       load;
  res_t       word, res_q;
  logic       strobe_q;

  assign load  = (!active_q || chip_q == 3'd0) && !empty_i;
  assign pop_o = load;

  always_comb begin
    active_d = active_q;
    chip_d   = chip_q;
    if (load) begin
      active_d = 1'b1;
      chip_d   = 3'(chain_len_i - 4'd1);
    end else if (active_q) begin
      if (chip_q == 3'd0) begin
        active_d = 1'b0;
      end else begin
        chip_d = chip_q - 3'd1;
      end
    end
  end

  always_comb begin
    word.frame_word = (chip_q == desc_q.device) ? {4'd0, desc_q.opcode, desc_q.data} : 16'h0000;
    word.frame_end  = (chip_q == 3'd0);
    word.last       = (chip_q == 3'd0) && desc_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      chip_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      active_q <= active_d;
      chip_q   <= chip_d;
      strobe_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      desc_q <= pop_data_i;
    end
    res_q <= word;
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

// File: hw/rtl/led_matrix_chain_frame_builder_unit.sv
`timescale 1ns / 1ps
// Frame builder for a daisy chain of LED matrix drivers. A command is taken when start is
// high and busy is low; busy stays high while the front end queues its frames, reading the
// row shadow first for led and column frames, and while the four-entry frame queue is full.
// The word emitter takes frames from the queue and puts out one chain word per cycle,
// farthest chip first, chain-length words per frame (written on cfg_wdata_i; 0 or above
// MaxChain counts as MaxChain), and frames already queued follow without a gap. A command
// yields zero, one or eight frames (column and clear give eight); its first word passes the
// read (led, column) and emit states, the frame queue, the emitter's load and its output
// register. The emitter sets the rate on longer chains; on a one- or two-chip chain the
// front end, returning to idle between commands, can leave gaps between frames. Results
// appear for one cycle with res_strobe_o and cannot be held off. Commands for a chip at or
// above the chain length, intensity of 16 or more and scan limit of 8 or more give no words.
// The row shadow reads as zero after reset via per-row valid bits, with no clearing pass.
module led_matrix_chain_frame_builder_unit #(
  parameter int unsigned MaxChain = lmcfb_pkg::MAX_CHAIN
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  lmcfb_pkg::cmd_t  cmd_i,
  input  logic             cfg_we_i,
  input  logic [3:0]       cfg_wdata_i,
  output logic             res_strobe_o,
  output lmcfb_pkg::res_t  res_o
);
  import lmcfb_pkg::*;

  logic [3:0] dev_cnt_q;
  logic [3:0] chain_len;
  logic       push, full, pop, empty;
  desc_t      push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_cnt_q <= 4'(MaxChain);
    end else if (cfg_we_i) begin
      dev_cnt_q <= cfg_wdata_i;
    end
  end

  assign chain_len = (dev_cnt_q == 4'd0 || dev_cnt_q > 4'(MaxChain)) ? 4'(MaxChain) : dev_cnt_q;

  lmcfb_front #(
    .MaxChain(MaxChain)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .chain_len_i (chain_len),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  lmcfb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  lmcfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chain_len_i  (chain_len),
    .pop_o        (pop),
    .pop_data_i   (pop_data),
    .empty_i      (empty),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule

// File: hw/rtl/lmcfb_chk.sv
`timescale 1ns / 1ps
module lmcfb_chk (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             res_strobe_o,
  input lmcfb_pkg::res_t  res_o
);

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.last |-> res_o.frame_end)
    else $error("last word not at frame end");

  a_frame_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !res_o.frame_end |=> res_strobe_o)
    else $error("gap inside a chain frame");

  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy && !$past(busy) |-> $past(start))
    else $error("busy rose without a transfer");

endmodule

bind led_matrix_chain_frame_builder_unit lmcfb_chk u_lmcfb_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .res_strobe_o (res_strobe_o),
  .res_o        (res_o)
);
